// ===== rtl/trial_division_factorizer_top_assert.svh =====
// Assertion macros used by the checker file of the factorizer.
`ifndef TRIAL_DIVISION_FACTORIZER_TOP_ASSERT_SVH
`define TRIAL_DIVISION_FACTORIZER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TDF_ASSERT_SAME(label, ck, rstn, ante, cons) \
	label: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("factorizer check failed in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define TDF_ASSERT_NEXT(label, ck, rstn, ante, cons) \
	label: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("factorizer check failed in the next cycle");

`endif

// ===== rtl/tdf_pkg.sv =====
package tdf_pkg;

	// Status that the divider reports back to the sequencer.
	typedef struct packed {
		logic done;
		logic rem_zero;
	} div_stat_t;

	localparam int unsigned EVEN_FACTOR       = 2;
	localparam int unsigned FIRST_ODD_DIVISOR = 3;
	localparam int unsigned DIVISOR_STEP      = 2;

endpackage

// ===== rtl/trial_division_factorizer_top.sv =====
// Prime factorizer by trial division.
// The request channel (req_valid, req_ready, number) takes one value to factor.
// The result channel (res_valid, res_ready, factor, last, empty_res) returns its
// prime factors in ascending order, repeats included, one transfer per factor;
// last marks the final one. Inputs 0 and 1 give a single transfer with factor 0,
// empty_res 1 and last 1.
// req_ready is high only while no value is being factored, so one value is in
// work at a time; the result register lets the next request be taken while the
// final factor still waits for the receiver.
// Each factor of two is taken out without the divider. Each odd trial divisor costs one
// pass of the restoring divider, and each further division by a found factor costs
// another pass; a 31-bit prime therefore takes about 23,000 divider passes.
// When the receiver stalls, the sequencer waits with its next factor until the
// result register is taken, so no factor is lost.
// Reset clears the sequencer and the result valid; the block then waits for a request.
module trial_division_factorizer_top import tdf_pkg::*; #(
	parameter int NUMBER_BITS = 31
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   req_valid,
	output logic                   req_ready,
	input  logic [NUMBER_BITS-1:0] number,
	output logic                   res_valid,
	input  logic                   res_ready,
	output logic [NUMBER_BITS-1:0] factor,
	output logic                   last,
	output logic                   empty_res
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_EMPTY = 3'd1;
	localparam logic [2:0] ST_STRIP = 3'd2;
	localparam logic [2:0] ST_DIVGO = 3'd3;
	localparam logic [2:0] ST_DIVW  = 3'd4;
	localparam logic [2:0] ST_EMITD = 3'd5;
	localparam logic [2:0] ST_FINAL = 3'd6;

	localparam logic [NUMBER_BITS-1:0] TWO   = NUMBER_BITS'(EVEN_FACTOR);
	localparam logic [NUMBER_BITS-1:0] THREE = NUMBER_BITS'(FIRST_ODD_DIVISOR);
	localparam logic [NUMBER_BITS-1:0] STEP  = NUMBER_BITS'(DIVISOR_STEP);

	logic [2:0]             state_q, state_d;
	logic [NUMBER_BITS-1:0] n_q, n_d;
	logic [NUMBER_BITS-1:0] d_q, d_d;
	logic                   res_valid_q;
	logic [NUMBER_BITS-1:0] factor_q;
	logic                   last_q;
	logic                   empty_q;

	logic                   out_free;
	logic                   emit;
	logic [NUMBER_BITS-1:0] emit_factor;
	logic                   emit_last;
	logic                   emit_empty;
	logic                   div_start;
	div_stat_t              div_stat;
	logic [NUMBER_BITS-1:0] div_quot;

	tdf_div #(.WIDTH(NUMBER_BITS)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (n_q),
		.divisor  (d_q),
		.stat     (div_stat),
		.quot     (div_quot)
	);

	assign out_free = !res_valid_q || res_ready;

	always_comb begin
		state_d     = state_q;
		n_d         = n_q;
		d_d         = d_q;
		emit        = 1'b0;
		emit_factor = '0;
		emit_last   = 1'b0;
		emit_empty  = 1'b0;
		div_start   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					if (number < TWO) begin
						state_d = ST_EMPTY;
					end else begin
						n_d     = number;
						state_d = ST_STRIP;
					end
				end
			end
			ST_EMPTY: begin
				if (out_free) begin
					emit       = 1'b1;
					emit_last  = 1'b1;
					emit_empty = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			ST_STRIP: begin
				if (!n_q[0]) begin
					if (out_free) begin
						emit        = 1'b1;
						emit_factor = TWO;
						emit_last   = (n_q == TWO);
						n_d         = n_q >> 1;
						if (n_q == TWO) begin
							state_d = ST_IDLE;
						end
					end
				end else begin
					d_d     = THREE;
					state_d = ST_DIVGO;
				end
			end
			ST_DIVGO: begin
				div_start = 1'b1;
				state_d   = ST_DIVW;
			end
			ST_DIVW: begin
				// The divisor exceeding the quotient means it passed the square root,
				// so what is left is prime (a cofactor equal to the divisor lands here too).
				if (div_stat.done) begin
					if (d_q > div_quot) begin
						state_d = ST_FINAL;
					end else if (div_stat.rem_zero) begin
						state_d = ST_EMITD;
					end else begin
						d_d     = d_q + STEP;
						state_d = ST_DIVGO;
					end
				end
			end
			ST_EMITD: begin
				if (out_free) begin
					emit        = 1'b1;
					emit_factor = d_q;
					n_d         = div_quot;
					state_d     = ST_DIVGO;
				end
			end
			ST_FINAL: begin
				if (out_free) begin
					emit        = 1'b1;
					emit_factor = n_q;
					emit_last   = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		n_q <= n_d;
		d_q <= d_d;
		if (emit) begin
			factor_q <= emit_factor;
			last_q   <= emit_last;
			empty_q  <= emit_empty;
		end
	end

	assign req_ready = (state_q == ST_IDLE);
	assign res_valid = res_valid_q;
	assign factor    = factor_q;
	assign last      = last_q;
	assign empty_res = empty_q;

endmodule

// ===== rtl/tdf_div.sv =====
module tdf_div import tdf_pkg::*; #(
	parameter int WIDTH = 31
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [WIDTH-1:0] dividend,
	input  logic [WIDTH-1:0] divisor,
	output div_stat_t        stat,
	output logic [WIDTH-1:0] quot
);

	localparam int CNT_W = $clog2(WIDTH + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [WIDTH-1:0] a_q;
	logic [WIDTH-1:0] b_q;
	logic [WIDTH-1:0] r_q;

	logic [WIDTH:0]   trial;
	logic [WIDTH:0]   diff;
	logic             ge;
	logic [WIDTH-1:0] r_next;

	// Restoring division: one quotient bit per cycle, shifted into the dividend register.
	always_comb begin
		trial  = {r_q, a_q[WIDTH-1]};
		diff   = trial - {1'b0, b_q};
		ge     = trial >= {1'b0, b_q};
		r_next = ge ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(WIDTH);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= dividend;
			b_q <= divisor;
			r_q <= '0;
		end else if (busy_q) begin
			a_q <= {a_q[WIDTH-2:0], ge};
			r_q <= r_next;
		end
	end

	assign stat.done     = done_q;
	assign stat.rem_zero = (r_q == '0);
	assign quot          = a_q;

endmodule

// ===== rtl/tdf_checker.sv =====
`include "trial_division_factorizer_top_assert.svh"

module tdf_checker #(
	parameter int NUMBER_BITS = 31
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   req_valid,
	input logic                   req_ready,
	input logic [NUMBER_BITS-1:0] number,
	input logic                   res_valid,
	input logic                   res_ready,
	input logic [NUMBER_BITS-1:0] factor,
	input logic                   last,
	input logic                   empty_res
);

	// A stalled result keeps its payload until the transfer.
	`TDF_ASSERT_NEXT(a_stall_hold, clk, arst_n, res_valid && !res_ready, res_valid && $stable(factor) && $stable(last) && $stable(empty_res))

	// The empty result is always a single, final item with factor zero.
	`TDF_ASSERT_SAME(a_empty_form, clk, arst_n, res_valid && empty_res, last && (factor == '0))

	// Every real factor is at least two.
	`TDF_ASSERT_SAME(a_factor_min, clk, arst_n, res_valid && !empty_res, factor >= NUMBER_BITS'(2))

	// Only one value is factored at a time: a request transfer closes the request side.
	`TDF_ASSERT_NEXT(a_one_at_a_time, clk, arst_n, req_valid && req_ready, !req_ready)

endmodule

bind trial_division_factorizer_top tdf_checker #(.NUMBER_BITS(NUMBER_BITS)) u_tdf_checker (.*);

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
	import tdf_pkg::*;

	localparam int NB = 31;
	localparam longint unsigned MAX_NUMBER = (64'd1 << NB) - 1;
	// The largest 31-bit prime alone is searched up to its square root without any transfer.
	localparam int WATCHDOG_LIMIT = 3_000_000;
	localparam int ITEMS_PER_PHASE = 25;
	localparam int SETTLE_CYCLES = 200;

	typedef struct {
		logic [NB-1:0] factor;
		logic          last;
		logic          empty_res;
	} factor_item_t;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          req_valid = 1'b0;
	logic          req_ready;
	logic [NB-1:0] number = '0;
	logic          res_valid;
	logic          res_ready = 1'b0;
	logic [NB-1:0] factor;
	logic          last;
	logic          empty_res;

	logic [NB-1:0] pending_numbers[$];
	factor_item_t  expected_factors[$];
	int unsigned   req_sent = 0;
	int unsigned   req_taken = 0;
	int            idle_pct = 0;
	int            stall_pct = 0;
	int            errors = 0;
	int            quiet_cycles = 0;

	trial_division_factorizer_top #(.NUMBER_BITS(NB)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.number    (number),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.factor    (factor),
		.last      (last),
		.empty_res (empty_res)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// Appends the prime factors of one accepted number, smallest first.
	task automatic predict_factors(input logic [NB-1:0] value);
		longint unsigned n;
		longint unsigned d;
		factor_item_t    item;
		factor_item_t    list[$];
		n = value;
		if (n < 2) begin
			item.factor = '0;
			item.last = 1'b1;
			item.empty_res = 1'b1;
			expected_factors.push_back(item);
			return;
		end
		item.last = 1'b0;
		item.empty_res = 1'b0;
		while (n % EVEN_FACTOR == 0) begin
			item.factor = NB'(EVEN_FACTOR);
			list.push_back(item);
			n = n / EVEN_FACTOR;
		end
		for (d = FIRST_ODD_DIVISOR; d <= n / d; d += DIVISOR_STEP) begin
			while (n % d == 0) begin
				item.factor = d[NB-1:0];
				list.push_back(item);
				n = n / d;
			end
		end
		if (n > EVEN_FACTOR) begin
			item.factor = n[NB-1:0];
			list.push_back(item);
		end
		list[list.size() - 1].last = 1'b1;
		foreach (list[i])
			expected_factors.push_back(list[i]);
	endtask

	// Random values are kept cheap to factor: their largest prime factor stays small,
	// while shifts and products still spread ones and zeros over all bits.
	function automatic logic [NB-1:0] pick_number();
		longint unsigned n;
		longint unsigned f;
		int              mode;
		int              k;
		mode = $urandom_range(0, 99);
		if (mode < 15) begin
			n = $urandom_range(0, 4095);
		end else if (mode < 65) begin
			n = (mode < 45) ? 64'd1 : longint'($urandom_range(2, 50000));
			k = $urandom_range(1, 12);
			repeat (k) begin
				f = $urandom_range(2, 97);
				if (n * f <= MAX_NUMBER)
					n = n * f;
			end
		end else begin
			n = longint'($urandom_range(1, 16383)) << $urandom_range(0, 30);
			n = n & MAX_NUMBER;
		end
		return n[NB-1:0];
	endfunction

	// Checked at the rising edge, where the driver never pops the queue.
	task automatic wait_all_factored();
		do
			@(posedge clk);
		while (pending_numbers.size() != 0 || req_taken != req_sent
			|| expected_factors.size() != 0);
	endtask

	always @(negedge clk) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			number <= '0;
			res_ready <= 1'b0;
		end else begin
			res_ready <= ($urandom_range(0, 99) >= stall_pct);
			// A request stays on the bus until its transfer has been seen.
			if (!req_valid || req_taken == req_sent) begin
				if (pending_numbers.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
					number <= pending_numbers.pop_front();
					req_valid <= 1'b1;
					req_sent <= req_sent + 1;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		factor_item_t exp_item;
		if (arst_n) begin
			if (req_valid && req_ready) begin
				predict_factors(number);
				req_taken <= req_taken + 1;
			end
			if (res_valid && res_ready) begin
				if (expected_factors.size() == 0) begin
					$error("unexpected result transfer: factor %0d last %0b empty_res %0b",
						factor, last, empty_res);
					errors++;
				end else begin
					exp_item = expected_factors.pop_front();
					if (factor !== exp_item.factor) begin
						$error("factor: expected %0d, got %0d", exp_item.factor, factor);
						errors++;
					end
					if (last !== exp_item.last) begin
						$error("last: expected %0b, got %0b", exp_item.last, last);
						errors++;
					end
					if (empty_res !== exp_item.empty_res) begin
						$error("empty_res: expected %0b, got %0b", exp_item.empty_res,
							empty_res);
						errors++;
					end
				end
			end
			if ((req_valid && req_ready) || (res_valid && res_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("trial_division_factorizer_top verification failed");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed values: empty inputs, small and largest primes, powers, the longest list.
		pending_numbers.push_back(31'd0);
		pending_numbers.push_back(31'd1);
		pending_numbers.push_back(31'd2);
		pending_numbers.push_back(31'd3);
		pending_numbers.push_back(31'd4);
		pending_numbers.push_back(31'd6);
		pending_numbers.push_back(31'd9);
		pending_numbers.push_back(31'd12);
		pending_numbers.push_back(31'd25);
		pending_numbers.push_back(31'd97);
		pending_numbers.push_back(31'd30030);
		pending_numbers.push_back(31'd63001);
		pending_numbers.push_back(31'd65536);
		pending_numbers.push_back(31'd65537);
		pending_numbers.push_back(31'd1162261467);
		pending_numbers.push_back(31'h4000_0000);
		pending_numbers.push_back(31'h7FFF_FFFE);
		pending_numbers.push_back(31'h7FFF_FFFF);
		pending_numbers.push_back(31'd1);
		wait_all_factored();

		for (int phase = 0; phase < 4; phase++) begin
			@(posedge clk);
			case (phase)
				0: begin
					idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					idle_pct = 45;
					stall_pct = 0;
				end
				2: begin
					idle_pct = 0;
					stall_pct = 45;
				end
				default: begin
					idle_pct = 27;
					stall_pct = 27;
				end
			endcase
			repeat (ITEMS_PER_PHASE)
				pending_numbers.push_back(pick_number());
			// The sender holds off here until every factor has been transferred.
			wait_all_factored();
		end

		repeat (SETTLE_CYCLES) @(negedge clk);
		if (errors == 0) begin
			$display("trial_division_factorizer_top verification clean");
		end else begin
			$display("trial_division_factorizer_top verification failed");
		end
		$finish;
	end

endmodule
